### hw/rtl/utf8d_pkg.sv
// shared types, constants and helper functions of the utf-8 decoder
package utf8d_pkg;

  // field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;

  // queue between front and back
  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned MID_PTR_W = $clog2(MID_DEPTH);
  localparam int unsigned MID_CNT_W = $clog2(MID_DEPTH + 1);

  // result queue in the back
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // code point constants
  localparam logic [CP_W-1:0] CP_REPL    = 21'h00FFFD;
  localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_SUR_LO  = 21'h00D800;
  localparam logic [CP_W-1:0] CP_SUR_HI  = 21'h00DFFF;
  localparam logic [CP_W-1:0] CP_MIN_2B  = 21'h000080;
  localparam logic [CP_W-1:0] CP_MIN_3B  = 21'h000800;
  localparam logic [CP_W-1:0] CP_MIN_4B  = 21'h010000;

  // byte classes
  typedef enum logic [2:0] {
    KIND_ASCII,
    KIND_CONT,
    KIND_LEAD2,
    KIND_LEAD3,
    KIND_LEAD4,
    KIND_BAD
  } kind_e;

  // classified item passed from front to back
  typedef struct packed {
    kind_e      kind;
    logic [6:0] data;
    logic       last;
  } item_t;

  // one decoded result
  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            last;
  } result_t;

  // sort a byte into its class and keep its payload bits
  function automatic item_t classify(logic [BYTE_W-1:0] b, logic last);
    item_t it;
    it.last = last;
    it.data = b[6:0];
    if (b < 8'h80) begin
      it.kind = KIND_ASCII;
    end else if (b < 8'hC0) begin
      it.kind = KIND_CONT;
      it.data = {1'b0, b[5:0]};
    end else if (b < 8'hE0) begin
      it.kind = KIND_LEAD2;
      it.data = {2'b00, b[4:0]};
    end else if (b < 8'hF0) begin
      it.kind = KIND_LEAD3;
      it.data = {3'b000, b[3:0]};
    end else if (b < 8'hF5) begin
      it.kind = KIND_LEAD4;
      it.data = {4'b0000, b[2:0]};
    end else begin
      it.kind = KIND_BAD;
    end
    return it;
  endfunction

  // range, surrogate and overlong check of a finished sequence
  function automatic logic [CP_W-1:0] finish_value(logic [CP_W-1:0] v, logic [1:0] len);
    logic [CP_W-1:0] minv;
    case (len)
      2'd1:    minv = CP_MIN_2B;
      2'd2:    minv = CP_MIN_3B;
      default: minv = CP_MIN_4B;
    endcase
    if (v > CP_MAX || (v >= CP_SUR_LO && v <= CP_SUR_HI) || v < minv) begin
      return CP_REPL;
    end
    return v;
  endfunction

endpackage

### hw/rtl/utf8d_front.sv
// front: classifies input bytes and queues them for the back
module utf8d_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [utf8d_pkg::BYTE_W-1:0]  in_byte_i,
  input  logic                          in_last_i,
  output logic                          item_valid_o,
  output utf8d_pkg::item_t              item_o,
  input  logic                          item_take_i
);
  import utf8d_pkg::*;

  item_t                mem_q [MID_DEPTH];
  logic [MID_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [MID_CNT_W-1:0] cnt_q, cnt_d;
  logic                 wr_en, rd_en;

  // handshake
  assign full         = (cnt_q == MID_CNT_W'(MID_DEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign wr_en        = push && !full;
  assign rd_en        = item_take_i && item_valid_o;
  assign item_o       = mem_q[rd_q];

  // pointer and fill count
  always_comb begin
    wr_d  = wr_en ? wr_q + 1'b1 : wr_q;
    rd_d  = rd_en ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + MID_CNT_W'(wr_en) - MID_CNT_W'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // classified item storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= classify(in_byte_i, in_last_i);
    end
  end

endmodule

### hw/rtl/utf8d_back.sv
// back: sequence state, code point assembly and result queue
module utf8d_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_valid_i,
  input  utf8d_pkg::item_t            item_i,
  output logic                        item_take_o,
  output logic                        empty,
  input  logic                        pop,
  output logic [utf8d_pkg::CP_W-1:0]  code_point_o,
  output logic                        out_last_o
);
  import utf8d_pkg::*;

  logic [CP_W-1:0]     acc_q, acc_d;
  logic [1:0]          rem_q, rem_d;
  logic [1:0]          len_q, len_d;
  result_t             oq_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [OQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                rd_en;
  result_t             res [2];
  logic [1:0]          n_res;

  // take an item only while two result slots are free
  assign item_take_o  = item_valid_i && (cnt_q <= OQ_CNT_W'(OQ_DEPTH - 2));
  assign empty        = (cnt_q == '0);
  assign rd_en        = pop && !empty;
  assign code_point_o = oq_q[rd_q].cp;
  assign out_last_o   = oq_q[rd_q].last;

  // decode step: up to two results per item
  always_comb begin
    logic [CP_W-1:0] acc_n;
    logic [1:0]      rem_dec;
    logic            do_fresh;
    acc_d    = acc_q;
    rem_d    = rem_q;
    len_d    = len_q;
    n_res    = '0;
    res[0]   = '0;
    res[1]   = '0;
    acc_n    = {acc_q[CP_W-7:0], item_i.data[5:0]};
    rem_dec  = rem_q - 2'd1;
    do_fresh = 1'b0;
    if (item_take_o) begin
      if (rem_q != '0) begin
        if (item_i.kind == KIND_CONT) begin
          if (rem_dec == '0) begin
            res[0] = '{cp: finish_value(acc_n, len_q), last: item_i.last};
            n_res  = 2'd1;
            acc_d  = '0;
            rem_d  = '0;
            len_d  = '0;
          end else if (item_i.last) begin
            res[0] = '{cp: CP_REPL, last: 1'b1};
            n_res  = 2'd1;
            acc_d  = '0;
            rem_d  = '0;
            len_d  = '0;
          end else begin
            acc_d = acc_n;
            rem_d = rem_dec;
          end
        end else begin
          // interrupted sequence, then the byte starts afresh
          res[0]   = '{cp: CP_REPL, last: 1'b0};
          n_res    = 2'd1;
          acc_d    = '0;
          rem_d    = '0;
          len_d    = '0;
          do_fresh = 1'b1;
        end
      end else begin
        do_fresh = 1'b1;
      end

      // byte with no sequence pending
      if (do_fresh) begin
        case (item_i.kind)
          KIND_ASCII: begin
            res[n_res[0]] = '{cp: CP_W'(item_i.data), last: item_i.last};
            n_res         = n_res + 2'd1;
          end
          KIND_CONT, KIND_BAD: begin
            res[n_res[0]] = '{cp: CP_REPL, last: item_i.last};
            n_res         = n_res + 2'd1;
          end
          KIND_LEAD2, KIND_LEAD3, KIND_LEAD4: begin
            if (item_i.last) begin
              res[n_res[0]] = '{cp: CP_REPL, last: 1'b1};
              n_res         = n_res + 2'd1;
            end else begin
              acc_d = CP_W'(item_i.data);
              case (item_i.kind)
                KIND_LEAD2: rem_d = 2'd1;
                KIND_LEAD3: rem_d = 2'd2;
                default:    rem_d = 2'd3;
              endcase
              len_d = rem_d;
            end
          end
          default: begin
            res[n_res[0]] = '{cp: CP_REPL, last: item_i.last};
            n_res         = n_res + 2'd1;
          end
        endcase
      end

      // end of string clears everything
      if (item_i.last) begin
        acc_d = '0;
        rem_d = '0;
        len_d = '0;
      end
    end
  end

  // result queue pointers and count
  always_comb begin
    wr_d  = wr_q + OQ_PTR_W'(n_res);
    rd_d  = rd_en ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + OQ_CNT_W'(n_res) - OQ_CNT_W'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      rem_q <= '0;
      len_q <= '0;
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      acc_q <= acc_d;
      rem_q <= rem_d;
      len_q <= len_d;
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // result storage, two writes per cycle at most
  always_ff @(posedge clk_i) begin
    if (n_res != '0) begin
      oq_q[wr_q] <= res[0];
    end
    if (n_res == 2'd2) begin
      oq_q[wr_q + 1'b1] <= res[1];
    end
  end

endmodule

### hw/rtl/utf8_to_codepoint_decoder.sv
// utf-8 to code point decoder with replacement character, top level
// throughput: one byte per cycle while two result slots are free; a byte with two
//   results takes two result slots, so the sustained rate is set by the single read
//   port of the result queue
// reset: asynchronous active low; clears both queues and any pending sequence
module utf8_to_codepoint_decoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [utf8d_pkg::BYTE_W-1:0] in_byte_i,
  input  logic                        in_last_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [utf8d_pkg::CP_W-1:0]  code_point_o,
  output logic                        out_last_o
);
  import utf8d_pkg::*;

  logic  item_valid;
  logic  item_take;
  item_t item;

  // front: classify and queue bytes
  utf8d_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  // back: assemble code points
  utf8d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .empty        (empty),
    .pop          (pop),
    .code_point_o (code_point_o),
    .out_last_o   (out_last_o)
  );

  // results are always scalar values
  a_cp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> code_point_o <= CP_MAX)
    else $error("code point above range");

  a_cp_no_surrogate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (code_point_o < CP_SUR_LO || code_point_o > CP_SUR_HI))
    else $error("surrogate code point emitted");

  // the byte queue fills only through an accepted item
  a_full_by_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("byte queue filled without a push");

  // an item is taken only while the byte queue holds one
  a_take_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take |-> item_valid)
    else $error("item taken from empty byte queue");

endmodule

### dv/utf8_to_codepoint_decoder_tb.sv
`timescale 1ns / 100ps
// testbench of the utf-8 to code point decoder: scoreboard package and top module
package utf8d_tb_pkg;
  import utf8d_pkg::*;

  // predicts the code points of accepted bytes and checks the popped ones
  class cp_scoreboard;
    result_t         cp_due_q[$];
    logic [CP_W-1:0] acc;
    logic [1:0]      cont_left;
    logic [1:0]      cont_total;
    int unsigned     n_err;

    function new();
      drop_seq();
      n_err = 0;
    endfunction

    function void drop_seq();
      acc        = '0;
      cont_left  = 2'd0;
      cont_total = 2'd0;
    endfunction

    function void add_cp(logic [CP_W-1:0] cp, logic last);
      result_t r;
      r.cp   = cp;
      r.last = last;
      cp_due_q.push_back(r);
    endfunction

    function int unsigned pending();
      return cp_due_q.size();
    endfunction

    // out of range, surrogate and overlong values become the replacement
    function logic [CP_W-1:0] legal_or_repl(logic [CP_W-1:0] v, logic [1:0] n_cont);
      logic [CP_W-1:0] floor_v;
      case (n_cont)
        2'd1:    floor_v = CP_MIN_2B;
        2'd2:    floor_v = CP_MIN_3B;
        default: floor_v = CP_MIN_4B;
      endcase
      if (v > CP_MAX || v < floor_v || (v >= CP_SUR_LO && v <= CP_SUR_HI)) begin
        return CP_REPL;
      end
      return v;
    endfunction

    // byte seen with no sequence open
    function void start_fresh(logic [7:0] b, logic last);
      if (b < 8'h80) begin
        add_cp({13'd0, b}, last);
      end else if (b < 8'hC0 || b >= 8'hF5) begin
        add_cp(CP_REPL, last);
      end else begin
        if (b < 8'hE0) begin
          acc       = {16'd0, b[4:0]};
          cont_left = 2'd1;
        end else if (b < 8'hF0) begin
          acc       = {17'd0, b[3:0]};
          cont_left = 2'd2;
        end else begin
          acc       = {18'd0, b[2:0]};
          cont_left = 2'd3;
        end
        cont_total = cont_left;
        // lead on the final byte cannot complete
        if (last) begin
          add_cp(CP_REPL, 1'b1);
          drop_seq();
        end
      end
    endfunction

    // one accepted item
    function void note_byte(logic [7:0] b, logic last);
      if (cont_left != 2'd0) begin
        if (b[7:6] == 2'b10) begin
          acc       = {acc[CP_W-7:0], b[5:0]};
          cont_left = cont_left - 2'd1;
          if (cont_left == 2'd0) begin
            add_cp(legal_or_repl(acc, cont_total), last);
            drop_seq();
          end else if (last) begin
            add_cp(CP_REPL, 1'b1);
            drop_seq();
          end
        end else begin
          // interrupted sequence, then the byte starts over
          add_cp(CP_REPL, 1'b0);
          drop_seq();
          start_fresh(b, last);
        end
      end else begin
        start_fresh(b, last);
      end
      if (last) begin
        drop_seq();
      end
    endfunction

    task report(input string msg);
      $display("mismatch: %s", msg);
      n_err++;
    endtask

    // compare one popped result with the oldest expectation
    task check_result(input logic [CP_W-1:0] cp, input logic last);
      result_t due;
      if (cp_due_q.size() == 0) begin
        report($sformatf("unexpected code point %06h last %b", cp, last));
        return;
      end
      due = cp_due_q.pop_front();
      if (cp !== due.cp) begin
        report($sformatf("code point %06h, expected %06h", cp, due.cp));
      end
      if (last !== due.last) begin
        report($sformatf("last %b, expected %b (code point %06h)", last, due.last, due.cp));
      end
    endtask
  endclass

endpackage

module utf8_to_codepoint_decoder_tb;
  import utf8d_pkg::*;
  import utf8d_tb_pkg::*;

  localparam int unsigned N_BYTES     = 1650;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic              clk_i;
  logic              rst_ni;
  logic              push     = 1'b0;
  logic              full;
  logic [BYTE_W-1:0] in_byte  = 8'h01;
  logic              in_last  = 1'b0;
  logic              empty;
  logic              pop      = 1'b0;
  logic [CP_W-1:0]   code_point;
  logic              out_last;

  cp_scoreboard sb = new();
  logic [7:0]   str_q[$];
  int unsigned  n_sent    = 0;
  int unsigned  n_cycles  = 0;
  int unsigned  hold_left = 0;
  bit           hold_done = 1'b0;
  bit           paused    = 1'b0;

  utf8_to_codepoint_decoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .in_byte_i    (in_byte),
    .in_last_i    (in_last),
    .empty        (empty),
    .pop          (pop),
    .code_point_o (code_point),
    .out_last_o   (out_last)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // cycle limit
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("utf8_to_codepoint_decoder_tb: FAIL");
      $finish;
    end
  end

  // a stretch in the middle runs with no idling on either side
  function automatic bit idle_on();
    return !(n_sent >= 1100 && n_sent < 1400);
  endfunction

  function automatic logic [7:0] rand_cont();
    logic [5:0] r;
    r = 6'($urandom_range(63));
    return {2'b10, r};
  endfunction

  // one well-formed character with random content
  function automatic void add_valid();
    logic [20:0] cp;
    logic [7:0]  b;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        b = 8'($urandom_range(1, 127));
        str_q.push_back(b);
      end
      4, 5: begin
        cp = 21'($urandom_range(21'h80, 21'h7FF));
        str_q.push_back({3'b110, cp[10:6]});
        str_q.push_back({2'b10, cp[5:0]});
      end
      6, 7: begin
        cp = 21'($urandom_range(21'h800, 21'hFFFF));
        if (cp >= 21'hD800 && cp <= 21'hDFFF) begin
          cp = cp - 21'h5000;
        end
        str_q.push_back({4'b1110, cp[15:12]});
        str_q.push_back({2'b10, cp[11:6]});
        str_q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
        str_q.push_back({5'b11110, cp[20:18]});
        str_q.push_back({2'b10, cp[17:12]});
        str_q.push_back({2'b10, cp[11:6]});
        str_q.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  // one malformed piece
  function automatic void add_noise();
    logic [7:0] b;
    logic [4:0] r5;
    logic [3:0] r4;
    int         n;
    int         k;
    r5 = 5'($urandom_range(31));
    r4 = 4'($urandom_range(15));
    case ($urandom_range(6))
      0: str_q.push_back(rand_cont());
      1: begin
        b = 8'($urandom_range(8'hF5, 8'hFF));
        str_q.push_back(b);
      end
      // truncated sequence
      2: begin
        n = $urandom_range(1, 3);
        case (n)
          1:       b = 8'($urandom_range(8'hC2, 8'hDF));
          2:       b = 8'($urandom_range(8'hE1, 8'hEF));
          default: b = 8'($urandom_range(8'hF1, 8'hF4));
        endcase
        str_q.push_back(b);
        k = $urandom_range(n - 1);
        repeat (k) str_q.push_back(rand_cont());
      end
      // overlong forms
      3: begin
        case ($urandom_range(2))
          0: begin
            b = 8'($urandom_range(8'hC0, 8'hC1));
            str_q.push_back(b);
            str_q.push_back(rand_cont());
          end
          1: begin
            str_q.push_back(8'hE0);
            str_q.push_back({3'b100, r5});
            str_q.push_back(rand_cont());
          end
          default: begin
            str_q.push_back(8'hF0);
            str_q.push_back({4'b1000, r4});
            str_q.push_back(rand_cont());
            str_q.push_back(rand_cont());
          end
        endcase
      end
      // surrogate
      4: begin
        str_q.push_back(8'hED);
        str_q.push_back({3'b101, r5});
        str_q.push_back(rand_cont());
      end
      // above the largest code point
      5: begin
        b = 8'($urandom_range(8'h90, 8'hBF));
        str_q.push_back(8'hF4);
        str_q.push_back(b);
        str_q.push_back(rand_cont());
        str_q.push_back(rand_cont());
      end
      default: begin
        b = 8'($urandom_range(1, 255));
        str_q.push_back(b);
      end
    endcase
  endfunction

  // offer one item and wait until it is taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (idle_on() && $urandom_range(99) < 23) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push    <= 1'b1;
    in_byte <= b;
    in_last <= last;
    do @(posedge clk_i); while (full);
    sb.note_byte(b, last);
    n_sent++;
  endtask

  // send the built string, last flag on its final byte
  task automatic send_string();
    foreach (str_q[i]) begin
      send_byte(str_q[i], i == str_q.size() - 1);
    end
  endtask

  // result side: check popped items, random stalls, one long hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        sb.check_result(code_point, out_last);
      end
      if (!hold_done && n_sent >= 400) begin
        hold_done = 1'b1;
        hold_left = 300;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= !idle_on() || $urandom_range(99) >= 23;
      end
    end
  end

  // reset, directed strings, random strings, drain
  initial begin
    int n_sym;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ascii extremes
    str_q = '{8'h01, 8'h7F};
    send_string();
    // stray continuation, bad leads, smallest two-byte, overlong two-byte
    str_q = '{8'h80, 8'hF5, 8'hFF, 8'hC2, 8'h80, 8'hC0, 8'hAF};
    send_string();
    // surrogate, above range, interrupted sequence
    str_q = '{8'hED, 8'hA0, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80, 8'hE2, 8'h41};
    send_string();
    // incomplete at end of string
    str_q = '{8'hF0, 8'h9F};
    send_string();
    str_q = '{8'hE0};
    send_string();
    // largest code point
    str_q = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_string();
    // interruption on the final byte gives two results
    str_q = '{8'hC3, 8'hC3};
    send_string();

    // random strings, mostly well formed
    while (n_sent < N_BYTES) begin
      if (!paused && n_sent >= 1000) begin
        paused = 1'b1;
        push <= 1'b0;
        do @(posedge clk_i); while (sb.pending() != 0);
      end
      str_q.delete();
      n_sym = $urandom_range(1, 8);
      repeat (n_sym) begin
        if ($urandom_range(99) < 75) begin
          add_valid();
        end else begin
          add_noise();
        end
      end
      send_string();
    end
    push <= 1'b0;

    // drain, then wait for stray results
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d results never came", sb.pending()));
    end
    if (sb.n_err == 0) begin
      $display("utf8_to_codepoint_decoder_tb: PASS");
    end else begin
      $display("utf8_to_codepoint_decoder_tb: FAIL");
    end
    $finish;
  end

endmodule
